[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the polygon intersection RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication check failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication check failed");

`endif

[hw/rtl/psi_pkg.sv]
// ----------------------------------------------------------------------------
// Polygon segment intersection package
// Shared types and constants for the controller, datapath and top level.
// ----------------------------------------------------------------------------
package psi_pkg;

   localparam int COUNT_BITS   = 5;
   localparam int INDEX_BITS   = 4;
   localparam int SIDE_BITS    = 4;
   localparam int MIN_VERTICES = 2;

   localparam logic [COUNT_BITS-1:0] VERTEX_COUNT_RESET = 5'd4;

   localparam logic MODE_LOAD  = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   // Word index of the vertex count register on the configuration port.
   localparam logic REG_VERTEX_COUNT = 1'b0;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_WAIT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic capture;
      logic store;
      logic rd_en;
      logic rd_pair;
      logic flush;
   } cmd_type;

   typedef struct packed {
      logic side_valid;
      logic side_hit;
   } stat_type;

endpackage

[hw/rtl/psi_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port and single read port with registered read data.
// ----------------------------------------------------------------------------
module psi_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[hw/rtl/psi_datapath.sv]
// ----------------------------------------------------------------------------
// Polygon segment intersection datapath
// Vertex store and a five-stage side test pipeline that evaluates one
// polygon side per cycle against the captured query segment.
// ----------------------------------------------------------------------------
module psi_datapath #(
   parameter int MAX_VERTICES = 16,
   parameter int COORD_BITS   = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  psi_pkg::cmd_type                    cmd,
   input  logic [$clog2(MAX_VERTICES)-1:0]     rd_addr,
   input  logic [$clog2(MAX_VERTICES)-1:0]     rd_side,
   input  logic [psi_pkg::INDEX_BITS-1:0]      req_vertex_index,
   input  logic signed [COORD_BITS-1:0]        req_ax,
   input  logic signed [COORD_BITS-1:0]        req_ay,
   input  logic signed [COORD_BITS-1:0]        req_bx,
   input  logic signed [COORD_BITS-1:0]        req_by,
   output psi_pkg::stat_type                   stat,
   output logic [$clog2(MAX_VERTICES)-1:0]     stat_side
);

   localparam int CB = COORD_BITS;
   localparam int AW = $clog2(MAX_VERTICES);
   localparam int IW = (AW > psi_pkg::INDEX_BITS) ? AW : psi_pkg::INDEX_BITS;
   localparam int DW = CB + 1;
   localparam int PW = 2 * DW;
   localparam int SW = PW + 1;

   function automatic logic in_span(input logic signed [CB-1:0] v,
                                    input logic signed [CB-1:0] e0,
                                    input logic signed [CB-1:0] e1);
      return ((v >= e0) && (v <= e1)) || ((v >= e1) && (v <= e0));
   endfunction

   function automatic logic unit_ratio(input logic signed [SW-1:0] num,
                                       input logic signed [SW-1:0] den);
      logic den_pos;
      den_pos = !den[SW-1] && (den != '0);
      if (den_pos) begin
         return !num[SW-1] && (num <= den);
      end
      return (num[SW-1] || (num == '0)) && (num >= den);
   endfunction

   // Vertex store.
   logic [IW-1:0]     widx;
   logic              store_we;
   logic [2*CB-1:0]   rdata;

   assign widx     = IW'(req_vertex_index);
   assign store_we = cmd.store && (32'(req_vertex_index) < 32'(MAX_VERTICES));

   psi_ram #(
      .WIDTH(2 * CB),
      .DEPTH(MAX_VERTICES)
   ) u_store (
      .clock(clock),
      .we(store_we),
      .waddr(widx[AW-1:0]),
      .wdata({req_ay, req_ax}),
      .raddr(rd_addr),
      .rdata(rdata)
   );

   // Captured query segment.
   logic signed [CB-1:0] ax_ff, ay_ff, bx_ff, by_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         ax_ff <= req_ax;
         ay_ff <= req_ay;
         bx_ff <= req_bx;
         by_ff <= req_by;
      end
   end

   // Stage 1: read data returns; the previous vertex forms the side start.
   logic            v1_ff, pair1_ff;
   logic [AW-1:0]   side1_ff;
   logic [2*CB-1:0] prev_ff;
   logic signed [CB-1:0] rx, ry, sx, sy;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= cmd.rd_en && !cmd.flush;
      end
   end

   always_ff @(posedge clock) begin
      pair1_ff <= cmd.rd_pair;
      side1_ff <= rd_side;
      if (v1_ff) begin
         prev_ff <= rdata;
      end
   end

   assign rx = prev_ff[CB-1:0];
   assign ry = prev_ff[2*CB-1:CB];
   assign sx = rdata[CB-1:0];
   assign sy = rdata[2*CB-1:CB];

   // Stage 2: coordinate differences and bounding box flags.
   logic                 v2_ff;
   logic [AW-1:0]        side2_ff;
   logic [3:0]           fl2_ff, fl2_in;
   logic signed [DW-1:0] dsx_ff, dsy_ff, dabx_ff, daby_ff, darx_ff, dary_ff;
   logic signed [DW-1:0] dsx_in, dsy_in, dabx_in, daby_in, darx_in, dary_in;

   always_comb begin
      dsx_in  = {sx[CB-1], sx} - {rx[CB-1], rx};
      dsy_in  = {sy[CB-1], sy} - {ry[CB-1], ry};
      dabx_in = {ax_ff[CB-1], ax_ff} - {bx_ff[CB-1], bx_ff};
      daby_in = {ay_ff[CB-1], ay_ff} - {by_ff[CB-1], by_ff};
      darx_in = {ax_ff[CB-1], ax_ff} - {rx[CB-1], rx};
      dary_in = {ay_ff[CB-1], ay_ff} - {ry[CB-1], ry};
      fl2_in[0] = in_span(rx, ax_ff, bx_ff) && in_span(ry, ay_ff, by_ff);
      fl2_in[1] = in_span(sx, ax_ff, bx_ff) && in_span(sy, ay_ff, by_ff);
      fl2_in[2] = in_span(ax_ff, rx, sx) && in_span(ay_ff, ry, sy);
      fl2_in[3] = in_span(bx_ff, rx, sx) && in_span(by_ff, ry, sy);
   end

   // Stage 3: products.
   logic                 v3_ff;
   logic [AW-1:0]        side3_ff;
   logic [3:0]           fl3_ff;
   logic signed [PW-1:0] p0_ff, p1_ff, p2_ff, p3_ff, p4_ff, p5_ff;

   // Stage 4: determinant and numerators.
   logic                 v4_ff;
   logic [AW-1:0]        side4_ff;
   logic [3:0]           fl4_ff;
   logic signed [SW-1:0] det_ff, tn_ff, un_ff;

   // Stage 5: side verdict.
   logic                 v5_ff, hit5_ff, hit5_in;
   logic [AW-1:0]        side5_ff;

   always_comb begin
      if (det_ff == '0) begin
         hit5_in = ((un_ff == '0) && (fl4_ff[0] || fl4_ff[1])) ||
                   ((tn_ff == '0) && (fl4_ff[2] || fl4_ff[3]));
      end else begin
         hit5_in = unit_ratio(tn_ff, det_ff) && unit_ratio(un_ff, det_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff && pair1_ff && !cmd.flush;
         v3_ff <= v2_ff && !cmd.flush;
         v4_ff <= v3_ff && !cmd.flush;
         v5_ff <= v4_ff && !cmd.flush;
      end
   end

   always_ff @(posedge clock) begin
      side2_ff <= side1_ff;
      fl2_ff   <= fl2_in;
      dsx_ff   <= dsx_in;
      dsy_ff   <= dsy_in;
      dabx_ff  <= dabx_in;
      daby_ff  <= daby_in;
      darx_ff  <= darx_in;
      dary_ff  <= dary_in;

      side3_ff <= side2_ff;
      fl3_ff   <= fl2_ff;
      p0_ff    <= dsx_ff * daby_ff;
      p1_ff    <= dabx_ff * dsy_ff;
      p2_ff    <= dsx_ff * dary_ff;
      p3_ff    <= dsy_ff * darx_ff;
      p4_ff    <= daby_ff * darx_ff;
      p5_ff    <= dabx_ff * dary_ff;

      side4_ff <= side3_ff;
      fl4_ff   <= fl3_ff;
      det_ff   <= {p0_ff[PW-1], p0_ff} - {p1_ff[PW-1], p1_ff};
      tn_ff    <= {p2_ff[PW-1], p2_ff} - {p3_ff[PW-1], p3_ff};
      un_ff    <= {p4_ff[PW-1], p4_ff} - {p5_ff[PW-1], p5_ff};

      side5_ff <= side4_ff;
      hit5_ff  <= hit5_in;
   end

   assign stat.side_valid = v5_ff;
   assign stat.side_hit   = hit5_ff;
   assign stat_side       = side5_ff;

endmodule

[hw/rtl/psi_ctrl.sv]
// ----------------------------------------------------------------------------
// Polygon segment intersection controller
// Sequences vertex reads for a query, watches side verdicts, and issues
// one result per transaction.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module psi_ctrl #(
   parameter int MAX_VERTICES = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic                                req_mode,
   input  logic [psi_pkg::COUNT_BITS-1:0]      vertex_count,
   output logic                                busy,
   output logic                                rsp_valid,
   output logic                                rsp_hit,
   output logic [psi_pkg::SIDE_BITS-1:0]       rsp_hit_side,
   output psi_pkg::cmd_type                    cmd,
   output logic [$clog2(MAX_VERTICES)-1:0]     rd_addr,
   output logic [$clog2(MAX_VERTICES)-1:0]     rd_side,
   input  psi_pkg::stat_type                   stat,
   input  logic [$clog2(MAX_VERTICES)-1:0]     stat_side
);

   localparam int AW = $clog2(MAX_VERTICES);
   localparam int CW = $clog2(MAX_VERTICES + 1);
   localparam int IW = (AW > psi_pkg::SIDE_BITS) ? AW : psi_pkg::SIDE_BITS;

   psi_pkg::state_type state_ff, state_in;
   logic [CW-1:0]      k_ff, k_in;
   logic               hit_ff, hit_in;
   logic [psi_pkg::SIDE_BITS-1:0] side_ff, side_in;

   logic [CW-1:0] n_eff;
   logic [CW-1:0] last_w;
   logic [CW-1:0] side_w;
   logic [IW-1:0] stat_wide;
   logic          accept;

   always_comb begin
      if (32'(vertex_count) < 32'(psi_pkg::MIN_VERTICES)) begin
         n_eff = CW'(psi_pkg::MIN_VERTICES);
      end else if (32'(vertex_count) > 32'(MAX_VERTICES)) begin
         n_eff = CW'(MAX_VERTICES);
      end else begin
         n_eff = CW'(vertex_count);
      end
   end

   assign last_w    = n_eff - CW'(1);
   assign side_w    = k_ff - CW'(1);
   assign stat_wide = IW'(stat_side);
   assign accept    = start && !busy;

   assign rd_addr = (k_ff == n_eff) ? '0 : k_ff[AW-1:0];
   assign rd_side = side_w[AW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= psi_pkg::ST_IDLE;
         k_ff     <= '0;
         hit_ff   <= 1'b0;
         side_ff  <= '0;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
         hit_ff   <= hit_in;
         side_ff  <= side_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      k_in        = k_ff;
      hit_in      = hit_ff;
      side_in     = side_ff;
      cmd.capture = 1'b0;
      cmd.store   = 1'b0;
      cmd.rd_en   = 1'b0;
      cmd.rd_pair = (k_ff != '0);
      cmd.flush   = 1'b0;
      case (state_ff)
         psi_pkg::ST_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               hit_in      = 1'b0;
               side_in     = '0;
               k_in        = '0;
               if (req_mode == psi_pkg::MODE_LOAD) begin
                  cmd.store = 1'b1;
                  state_in  = psi_pkg::ST_DONE;
               end else begin
                  state_in  = psi_pkg::ST_READ;
               end
            end
         end
         psi_pkg::ST_READ, psi_pkg::ST_WAIT: begin
            if (stat.side_valid && stat.side_hit) begin
               hit_in    = 1'b1;
               side_in   = stat_wide[psi_pkg::SIDE_BITS-1:0];
               cmd.flush = 1'b1;
               state_in  = psi_pkg::ST_DONE;
            end else if (stat.side_valid && (stat_side == last_w[AW-1:0])) begin
               cmd.flush = 1'b1;
               state_in  = psi_pkg::ST_DONE;
            end else if (state_ff == psi_pkg::ST_READ) begin
               cmd.rd_en = 1'b1;
               k_in      = k_ff + CW'(1);
               if (k_ff == n_eff) begin
                  state_in = psi_pkg::ST_WAIT;
               end
            end
         end
         psi_pkg::ST_DONE: begin
            state_in = psi_pkg::ST_IDLE;
         end
         default: begin
            state_in = psi_pkg::ST_IDLE;
         end
      endcase
   end

   assign busy         = (state_ff != psi_pkg::ST_IDLE);
   assign rsp_valid    = (state_ff == psi_pkg::ST_DONE);
   assign rsp_hit      = hit_ff;
   assign rsp_hit_side = side_ff;

   `ASSERT_NEXT(a_done_one_cycle, clock, reset, state_ff == psi_pkg::ST_DONE, state_ff == psi_pkg::ST_IDLE)
   `ASSERT_IMPLY(a_rd_in_range, clock, reset, cmd.rd_en, 32'(rd_addr) < 32'(n_eff))
   `ASSERT_IMPLY(a_verdict_while_busy, clock, reset, stat.side_valid, state_ff == psi_pkg::ST_READ || state_ff == psi_pkg::ST_WAIT)
   `ASSERT_NEXT(a_load_responds, clock, reset, accept && (req_mode == psi_pkg::MODE_LOAD), rsp_valid && !rsp_hit)

endmodule

[hw/rtl/polygon_segment_intersect.sv]
// ----------------------------------------------------------------------------
// Polygon segment intersection
// Tests a query segment against every side of a stored polygon, including
// the closing side, and reports the first side that it meets.
// ----------------------------------------------------------------------------
// A transaction is accepted when start is high and busy is low, and each
// transaction returns exactly one result on rsp_valid, held for one cycle;
// the receiver cannot stall it. A load transaction writes one vertex and
// answers in the next cycle. A query with n vertices in use reads the
// vertex store once per cycle, up to n + 1 reads in all through its single
// read port, and feeds a five-stage side test pipeline; the result follows
// the verdict on the last side or on the first side that is hit. A new
// transaction is accepted in the cycle after the result.
module polygon_segment_intersect #(
   parameter int MAX_VERTICES = 16,
   parameter int COORD_BITS   = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_mode,
   input  logic [psi_pkg::INDEX_BITS-1:0]      req_vertex_index,
   input  logic signed [COORD_BITS-1:0]        req_ax,
   input  logic signed [COORD_BITS-1:0]        req_ay,
   input  logic signed [COORD_BITS-1:0]        req_bx,
   input  logic signed [COORD_BITS-1:0]        req_by,
   output logic                                rsp_valid,
   output logic                                rsp_hit,
   output logic [psi_pkg::SIDE_BITS-1:0]       rsp_hit_side,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [2:0]                          paddr,
   input  logic [31:0]                         pwdata,
   output logic [31:0]                         prdata,
   output logic                                pready
);

   localparam int AW = $clog2(MAX_VERTICES);

   logic [psi_pkg::COUNT_BITS-1:0] count_ff;
   logic                           csr_write;
   logic                           csr_hit;

   psi_pkg::cmd_type  cmd;
   psi_pkg::stat_type stat;
   logic [AW-1:0]     rd_addr;
   logic [AW-1:0]     rd_side;
   logic [AW-1:0]     stat_side;

   assign pready    = 1'b1;
   assign csr_hit   = (paddr[2] == psi_pkg::REG_VERTEX_COUNT);
   assign csr_write = psel && penable && pwrite && pready && csr_hit;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= psi_pkg::VERTEX_COUNT_RESET;
      end else if (csr_write) begin
         count_ff <= pwdata[psi_pkg::COUNT_BITS-1:0];
      end
   end

   assign prdata = csr_hit ? 32'(count_ff) : '0;

   psi_ctrl #(
      .MAX_VERTICES(MAX_VERTICES)
   ) u_ctrl (
      .clock(clock),
      .reset(reset),
      .start(start),
      .req_mode(req_mode),
      .vertex_count(count_ff),
      .busy(busy),
      .rsp_valid(rsp_valid),
      .rsp_hit(rsp_hit),
      .rsp_hit_side(rsp_hit_side),
      .cmd(cmd),
      .rd_addr(rd_addr),
      .rd_side(rd_side),
      .stat(stat),
      .stat_side(stat_side)
   );

   psi_datapath #(
      .MAX_VERTICES(MAX_VERTICES),
      .COORD_BITS(COORD_BITS)
   ) u_datapath (
      .clock(clock),
      .reset(reset),
      .cmd(cmd),
      .rd_addr(rd_addr),
      .rd_side(rd_side),
      .req_vertex_index(req_vertex_index),
      .req_ax(req_ax),
      .req_ay(req_ay),
      .req_bx(req_bx),
      .req_by(req_by),
      .stat(stat),
      .stat_side(stat_side)
   );

endmodule
